// File: hw/rtl/cfws_pkg.sv
package cfws_pkg;

  // Request codes on in_ch.req_type
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // Result status codes
  typedef logic [2:0] status_t;

  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_MATCH    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

// File: hw/rtl/cfws_if.sv
interface cfws_in_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [DW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cfws_out_if #(
  parameter int DW = 32,
  parameter int CW = 4
);
  import cfws_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [CW-1:0]        match_position;
  logic                 front_valid;
  logic signed [DW-1:0] front_value;
  logic signed [DW-1:0] back_value;
  logic [CW-1:0]        fill_count;
  logic                 last;

  modport source (
    output valid, output status, output match_position, output front_valid,
    output front_value, output back_value, output fill_count, output last,
    input ready
  );
  modport sink (
    input valid, input status, input match_position, input front_valid,
    input front_value, input back_value, input fill_count, input last,
    output ready
  );
endinterface

// File: hw/rtl/circular_fifo_with_search.sv
// Ring-buffer FIFO of signed words with an in-place search.
//
// in_ch carries one request per item: insert a word at the back, remove the
// oldest word, or search all held words for a key. out_ch returns result
// items; each shows the status, the 1-based match position, and a snapshot
// of fill count, front and back words after the request. The final result
// of a request has last set. A search gives one result per match, or one
// not-found result.
//
// Acceptance to result: insert, rejected requests and a remove that empties
// the queue pass S_REPORT; a remove that leaves entries passes S_FRONT first
// (the new front word is read from the entry RAM). A search passes S_SEARCH
// and S_FINAL, paced by the single RAM read port, which streams one entry per
// cycle into the comparator while no held match waits on a busy result register.
// One request is worked on at a time; in_ch.ready is high when the control
// FSM is idle, and the next request may enter while a result still waits.
// When out_ch stalls, the result register holds and the FSM waits.
// Reset sets the pointers to an empty ring and clears the fill count; the entry RAM is not cleared.
module circular_fifo_with_search #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cfws_in_if.sink     in_ch,
  cfws_out_if.source  out_ch
);
  import cfws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FRONT  = 5'b00010,
    S_REPORT = 5'b00100,
    S_SEARCH = 5'b01000,
    S_FINAL  = 5'b10000
  } state_t;

  // Entry RAM: one write port, one registered read port
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;

  // Control state
  state_t        state_r,      state_nxt;
  logic [AW-1:0] head_r,       head_nxt;
  logic [AW-1:0] tail_r,       tail_nxt;
  logic [CW-1:0] count_r,      count_nxt;
  logic          rd_valid_r,   rd_valid_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic          out_valid_r,  out_valid_nxt;

  // Working payload
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r,  back_nxt;
  logic [DATA_WIDTH-1:0] key_r,   key_nxt;
  status_t               op_status_r, op_status_nxt;
  logic [AW-1:0]         rd_ptr_r,    rd_ptr_nxt;
  logic [CW-1:0]         scan_cnt_r,  scan_cnt_nxt;
  logic [CW-1:0]         cmp_pos_r,   cmp_pos_nxt;
  logic [CW-1:0]         pend_pos_r,  pend_pos_nxt;

  // Result register
  status_t               out_status_r, out_status_nxt;
  logic [CW-1:0]         out_pos_r,    out_pos_nxt;
  logic                  out_fvalid_r, out_fvalid_nxt;
  logic [DATA_WIDTH-1:0] out_front_r,  out_front_nxt;
  logic [DATA_WIDTH-1:0] out_back_r,   out_back_nxt;
  logic [CW-1:0]         out_fill_r,   out_fill_nxt;
  logic                  out_last_r,   out_last_nxt;

  logic          out_free;
  logic          hit;
  logic          load;
  status_t       ld_status;
  logic [CW-1:0] ld_pos;
  logic          ld_last;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign hit         = rd_valid_r && (rd_data_r == key_r);
  assign head_inc    = wrap_inc(head_r);
  assign tail_inc    = wrap_inc(tail_r);
  assign wr_addr     = tail_inc;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    rd_valid_nxt   = rd_valid_r;
    pend_valid_nxt = pend_valid_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    key_nxt        = key_r;
    op_status_nxt  = op_status_r;
    rd_ptr_nxt     = rd_ptr_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_pos_nxt    = cmp_pos_r;
    pend_pos_nxt   = pend_pos_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rd_ptr_r;
    load           = 1'b0;
    ld_status      = ST_DONE;
    ld_pos         = '0;
    ld_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.req_type)
            REQ_INSERT: begin
              state_nxt = S_REPORT;
              if (count_r == FULL_COUNT) begin
                op_status_nxt = ST_FULL;
              end else begin
                // Write at the new tail; keep a copy of the back word
                op_status_nxt = ST_DONE;
                wr_en         = 1'b1;
                tail_nxt      = tail_inc;
                back_nxt      = in_ch.value;
                count_nxt     = count_r + 1'b1;
                if (count_r == '0) begin
                  front_nxt = in_ch.value;
                end
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                op_status_nxt = ST_EMPTY;
                state_nxt     = S_REPORT;
              end else begin
                op_status_nxt = ST_DONE;
                head_nxt      = head_inc;
                count_nxt     = count_r - 1'b1;
                if (count_r == CW'(1)) begin
                  state_nxt = S_REPORT;
                end else begin
                  // Fetch the new front word
                  rd_en     = 1'b1;
                  rd_addr   = head_inc;
                  state_nxt = S_FRONT;
                end
              end
            end
            REQ_SEARCH: begin
              key_nxt        = in_ch.value;
              rd_ptr_nxt     = head_r;
              scan_cnt_nxt   = '0;
              rd_valid_nxt   = 1'b0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_SEARCH;
            end
            default: begin
              // Unused code: report the current snapshot
              op_status_nxt = ST_DONE;
              state_nxt     = S_REPORT;
            end
          endcase
        end
      end

      S_FRONT: begin
        front_nxt = rd_data_r;
        state_nxt = S_REPORT;
      end

      S_REPORT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = op_status_r;
          state_nxt = S_IDLE;
        end
      end

      S_SEARCH: begin
        // Hold back one match so the final one can carry last; stall only
        // when a held match must leave and the result register is busy.
        if (!(hit && pend_valid_r && !out_free)) begin
          if (hit) begin
            if (pend_valid_r) begin
              load      = 1'b1;
              ld_status = ST_MATCH;
              ld_pos    = pend_pos_r;
              ld_last   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_pos_nxt   = cmp_pos_r;
          end
          if (scan_cnt_r != count_r) begin
            rd_en        = 1'b1;
            rd_addr      = rd_ptr_r;
            rd_ptr_nxt   = wrap_inc(rd_ptr_r);
            scan_cnt_nxt = scan_cnt_r + 1'b1;
            cmp_pos_nxt  = scan_cnt_r + 1'b1;
            rd_valid_nxt = 1'b1;
          end else begin
            rd_valid_nxt = 1'b0;
            state_nxt    = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          load      = 1'b1;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
          if (pend_valid_r) begin
            ld_status = ST_MATCH;
            ld_pos    = pend_pos_r;
          end else begin
            ld_status = ST_NOTFOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: snapshot the queue as it stands after the request
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_fvalid_nxt = out_fvalid_r;
    out_front_nxt  = out_front_r;
    out_back_nxt   = out_back_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ld_status;
      out_pos_nxt    = ld_pos;
      out_fvalid_nxt = (count_r != '0);
      out_front_nxt  = (count_r != '0) ? front_r : '0;
      out_back_nxt   = (count_r != '0) ? back_r : '0;
      out_fill_nxt   = count_r;
      out_last_nxt   = ld_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= LAST_SLOT;
      count_r      <= '0;
      rd_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      rd_valid_r   <= rd_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    key_r        <= key_nxt;
    op_status_r  <= op_status_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_pos_r    <= cmp_pos_nxt;
    pend_pos_r   <= pend_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_fvalid_r <= out_fvalid_nxt;
    out_front_r  <= out_front_nxt;
    out_back_r   <= out_back_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Entry RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.match_position = out_pos_r;
  assign out_ch.front_valid    = out_fvalid_r;
  assign out_ch.front_value    = out_front_r;
  assign out_ch.back_value     = out_back_r;
  assign out_ch.fill_count     = out_fill_r;
  assign out_ch.last           = out_last_r;

  // Fill count never runs past the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("fill count exceeds depth");

  // An accepted insert into a non-full queue grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_INSERT && count_r != FULL_COUNT)
    |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance fill count");

  // The scan never walks past the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> scan_cnt_r <= count_r)
    else $error("search scan beyond fill count");

  // Read data is only marked for compare while searching
  a_rd_valid_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> state_r == S_SEARCH)
    else $error("compare data outside search");

  // A reported match lies within the held entries
  a_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_MATCH)
    |-> (out_pos_r != '0 && out_pos_r <= out_fill_r))
    else $error("match position out of range");

endmodule
